[rtl/slcd_pkg.sv]
`default_nettype none
package slcd_pkg;

  localparam int MAX_FRAME = 64;
  localparam int IDX_W     = $clog2(MAX_FRAME);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BYTE_W    = 8;
  localparam int ST_W      = 2;

  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_FRAME);
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME);

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_SUM = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_LEN = 2'd2;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h77;

  // frame store write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  // end-of-frame event from the parser
  typedef struct packed {
    logic              replay;
    logic              error;
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] len;
    logic [CNT_W-1:0]  cnt;
  } evt_t;

endpackage
`default_nettype wire

[rtl/sync_length_checksum_deframer.sv]
// an error word is shown in the cycle after the length or checksum byte is taken
// a good frame shows its command byte after the checksum byte, through one store
// read (RP_READ) and one output load (RP_LOAD), and each further byte likewise
// one received byte per cycle outside replay while output is free; none in replay
// reset: async active low, parser hunts, sync values 0x55/0x77, store not cleared
`default_nettype none
module sync_length_checksum_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [slcd_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  wire logic                        rx_valid_i,
  output logic                             rx_ready_o,
  input  wire logic [slcd_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [slcd_pkg::ST_W-1:0]        status_o,
  output logic [slcd_pkg::BYTE_W-1:0]      data_byte_o,
  output logic [slcd_pkg::IDX_W-1:0]       byte_index_o,
  output logic [slcd_pkg::BYTE_W-1:0]      frame_length_o,
  output logic                             last_o
);
  import slcd_pkg::*;

  wr_t  wr;
  evt_t evt;
  logic rp_idle;
  logic fire;

  assign rx_ready_o = rp_idle && (!out_valid_o || out_ready_i);
  assign fire       = rx_valid_i && rx_ready_o;

  slcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_i),
    .wr_o        (wr),
    .evt_o       (evt)
  );

  slcd_replay u_replay (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .evt_i          (evt),
    .idle_o         (rp_idle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

[rtl/slcd_parser.sv]
`default_nettype none
module slcd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [slcd_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  wire logic                       fire_i,
  input  wire logic [slcd_pkg::BYTE_W-1:0] rx_byte_i,
  output slcd_pkg::wr_t                   wr_o,
  output slcd_pkg::evt_t                  evt_o
);
  import slcd_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } ph_e;

  ph_e               phase_q, phase_d;
  logic [BYTE_W-1:0] exp_len_q, exp_len_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] sync_first_q, sync_second_q;

  always_comb begin
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    cnt_inc   = cnt_q + CNT_W'(1);
    wr_o      = '0;
    evt_o     = '0;
    evt_o.len = exp_len_q;
    evt_o.cnt = cnt_q;
    if (fire_i) begin
      case (phase_q)
        PH_SYNC1: begin
          if (rx_byte_i == sync_first_q) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_d = (rx_byte_i == sync_second_q) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          exp_len_d = rx_byte_i;
          sum_d     = '0;
          if (rx_byte_i > MAX_LEN) begin
            evt_o.error  = 1'b1;
            evt_o.status = ST_BAD_LEN;
            evt_o.len    = rx_byte_i;
            phase_d      = PH_SYNC1;
          end else begin
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          wr_o.en   = 1'b1;
          wr_o.addr = '0;
          wr_o.data = rx_byte_i;
          cnt_d     = CNT_W'(1);
          sum_d     = sum_q + rx_byte_i;
          phase_d   = PH_DATA;
        end
        PH_DATA: begin
          if (cnt_q < MAX_CNT) begin
            wr_o.en   = 1'b1;
            wr_o.addr = cnt_q[IDX_W-1:0];
            wr_o.data = rx_byte_i;
            cnt_d     = cnt_inc;
          end
          sum_d = sum_q + rx_byte_i;
          // short lengths still take one payload byte
          if (BYTE_W'(cnt_d) >= exp_len_q) phase_d = PH_CSUM;
        end
        PH_CSUM: begin
          if (rx_byte_i == sum_q) begin
            evt_o.replay = 1'b1;
          end else begin
            evt_o.error  = 1'b1;
            evt_o.status = ST_BAD_SUM;
          end
          phase_d = PH_SYNC1;
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SYNC1;
      exp_len_q     <= '0;
      cnt_q         <= '0;
      sum_q         <= '0;
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      if (cfg_we_i && cfg_idx_i == CFG_SYNC_FIRST)  sync_first_q  <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CFG_SYNC_SECOND) sync_second_q <= cfg_wdata_i;
    end
  end

endmodule
`default_nettype wire

[rtl/slcd_replay.sv]
`default_nettype none
module slcd_replay (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire slcd_pkg::wr_t               wr_i,
  input  wire slcd_pkg::evt_t              evt_i,
  output logic                             idle_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [slcd_pkg::ST_W-1:0]        status_o,
  output logic [slcd_pkg::BYTE_W-1:0]      data_byte_o,
  output logic [slcd_pkg::IDX_W-1:0]       byte_index_o,
  output logic [slcd_pkg::BYTE_W-1:0]      frame_length_o,
  output logic                             last_o
);
  import slcd_pkg::*;

  typedef enum logic [1:0] {
    RP_IDLE = 2'd0,
    RP_READ = 2'd1,
    RP_LOAD = 2'd2
  } rp_e;

  logic [BYTE_W-1:0] store_q [MAX_FRAME];
  logic [BYTE_W-1:0] rd_data_q;

  rp_e               rp_q;
  logic [IDX_W-1:0]  k_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BYTE_W-1:0] len_q;
  logic              out_valid_q;
  logic [ST_W-1:0]   status_q;
  logic [BYTE_W-1:0] data_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BYTE_W-1:0] flen_q;
  logic              last_q;

  logic rd_en;
  logic last_w;
  logic out_free;
  logic load_err;
  logic load_ok;

  assign rd_en    = (rp_q == RP_READ);
  assign last_w   = ((CNT_W'(k_q) + CNT_W'(1)) == cnt_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_err = (rp_q == RP_IDLE) && evt_i.error;
  assign load_ok  = (rp_q == RP_LOAD) && out_free;

  // one write port from the parser, one read port for replay
  always_ff @(posedge clk_i) begin
    if (wr_i.en) store_q[wr_i.addr] <= wr_i.data;
    if (rd_en)   rd_data_q <= store_q[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= RP_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      data_q      <= '0;
      idx_q       <= '0;
      flen_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (load_err || load_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (rp_q)
        RP_IDLE: begin
          // input is only taken when the output word can be loaded
          if (evt_i.error) begin
            status_q    <= evt_i.status;
            data_q      <= '0;
            idx_q       <= '0;
            flen_q      <= evt_i.len;
            last_q      <= 1'b1;
          end else if (evt_i.replay) begin
            rp_q  <= RP_READ;
            k_q   <= '0;
            cnt_q <= evt_i.cnt;
            len_q <= evt_i.len;
          end
        end
        RP_READ: rp_q <= RP_LOAD;
        RP_LOAD: begin
          if (out_free) begin
            status_q    <= ST_OK;
            data_q      <= rd_data_q;
            idx_q       <= k_q;
            flen_q      <= len_q;
            last_q      <= last_w;
            if (last_w) begin
              rp_q <= RP_IDLE;
            end else begin
              k_q  <= k_q + IDX_W'(1);
              rp_q <= RP_READ;
            end
          end
        end
        default: rp_q <= RP_IDLE;
      endcase
    end
  end

  assign idle_o         = (rp_q == RP_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign data_byte_o    = data_q;
  assign byte_index_o   = idx_q;
  assign frame_length_o = flen_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

[rtl/slcd_checker.sv]
`default_nettype none
module slcd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        rx_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [slcd_pkg::ST_W-1:0]   status_o,
  input wire logic [slcd_pkg::BYTE_W-1:0] data_byte_o,
  input wire logic [slcd_pkg::IDX_W-1:0]  byte_index_o,
  input wire logic                        last_o
);
  import slcd_pkg::*;

  // error words are single, empty words
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> data_byte_o == '0 && byte_index_o == '0 && last_o)
    else $error("error word carries data");

  // no byte taken while a stalled word would be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !rx_ready_o)
    else $error("input taken while output stalled");

  // replay of a frame is not interleaved with new input
  a_replay_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && !last_o |-> !rx_ready_o)
    else $error("input taken during frame replay");

  // a good frame always holds at least command and one payload byte
  a_min_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK && last_o |-> byte_index_o != '0)
    else $error("good frame shorter than two bytes");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o))
    else $error("stalled output word changed");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_ready_o   (rx_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .data_byte_o  (data_byte_o),
  .byte_index_o (byte_index_o),
  .last_o       (last_o)
);
`default_nettype wire
